FILE: design/bvd_pkg.sv
// ----------------------------------------------------------------------------
// bvd_pkg - shared types and constants of the binary volume dilation unit
// Field widths, register indexes, item kinds and pipeline stage payloads.
// ----------------------------------------------------------------------------
package bvd_pkg;

    localparam int SIZE_W    = 9;   // configured extent
    localparam int POS_W     = 8;   // voxel position along one axis
    localparam int IDX_W     = 24;  // output index
    localparam int LIN_W     = 24;  // raster index of an input voxel
    localparam int TOT_W     = 25;  // voxel count of a whole volume
    localparam int DLY_W     = 17;  // plane + row + one voxel
    localparam int ZY_W      = 17;  // z * size_y
    localparam int SXY_W     = 17;  // size_x * size_y
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;
    localparam logic [SIZE_W-1:0] SIZE_MIN   = 9'd1;
    localparam int               SIZE_CAP    = 256;

    localparam logic KIND_VOXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    // stage 1: just accepted, store words being read
    typedef struct packed {
        logic              kind;
        logic              h;
        logic              has_x;
        logic              has_y;
        logic              interior;
        logic              last;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [POS_W-1:0]  z;
        logic [SIZE_W-1:0] sx;
        logic [SIZE_W-1:0] sy;
        logic [SIZE_W-1:0] sz;
    } s1_t;

    // stage 2: dilated value known, first products
    typedef struct packed {
        logic              kind;
        logic              dil;
        logic              last;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [SIZE_W-1:0] sx;
        logic [SIZE_W-1:0] sz;
        logic [ZY_W-1:0]   zy;
        logic [SXY_W-1:0]  sxy;
    } s2_t;

    // stage 3: row base, volume count and output delay
    typedef struct packed {
        logic              kind;
        logic              dil;
        logic              last;
        logic [POS_W-1:0]  x;
        logic [LIN_W-1:0]  q;
        logic [TOT_W-1:0]  total;
        logic [DLY_W-1:0]  delay;
    } s3_t;

endpackage

FILE: design/binary_volume_dilation_cube_unit.sv
// path: an accepted item moves through stages 1, 2, 3 and the output register
// throughput: one item per cycle unless a stall holds the pipeline; each voxel
// reads and at most once writes the row and plane stores, single-address 2-bit words
// reset: positions, x window, output index and drain flag clear; sizes go to
// 256; the stores keep no reset and need no clearing pass
// ----------------------------------------------------------------------------
// binary_volume_dilation_cube_unit - 3x3x3 binary dilation of a voxel stream
// Separable x, y and z ORs through a row store and a plane store, then a
// short pipeline that works out raster index, delay and border forcing.
// ----------------------------------------------------------------------------
module binary_volume_dilation_cube_unit
    import bvd_pkg::*;
#(
    parameter int MAX_X = 256,
    parameter int MAX_Y = 256,
    parameter int MAX_Z = 256
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic                 kind,
    input  logic                 voxel_in,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic                 voxel_out,
    output logic                 volume_last,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data
);

    localparam int XW = $clog2(MAX_X);
    localparam int YW = $clog2(MAX_Y);
    localparam logic [SIZE_W-1:0] CAP_X = SIZE_W'((MAX_X < SIZE_CAP) ? MAX_X : SIZE_CAP);
    localparam logic [SIZE_W-1:0] CAP_Y = SIZE_W'((MAX_Y < SIZE_CAP) ? MAX_Y : SIZE_CAP);
    localparam logic [SIZE_W-1:0] CAP_Z = SIZE_W'((MAX_Z < SIZE_CAP) ? MAX_Z : SIZE_CAP);

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] cap);
        logic [SIZE_W-1:0] r;
        begin
            r = (v < SIZE_MIN) ? SIZE_MIN : v;
            if (r > cap)
            begin
                r = cap;
            end
            return r;
        end
    endfunction

    // configuration
    logic [SIZE_W-1:0] size_x_reg, size_y_reg, size_z_reg;

    // sequential state
    logic [POS_W-1:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic [POS_W-1:0] pos_x_next, pos_y_next, pos_z_next;
    logic [1:0]       x_window_reg, x_window_next;
    logic [IDX_W-1:0] out_index_reg, out_index_next;
    logic             drain_pending_reg, drain_pending_next;

    // pipeline
    logic    s1_valid_reg, s2_valid_reg, s3_valid_reg;
    s1_t     s1_reg, s1_next;
    s2_t     s2_reg, s2_next;
    s3_t     s3_reg, s3_next;
    logic [XW-1:0] s1_cx_reg, cx_next;
    logic [YW-1:0] s1_cy_reg, cy_next;
    logic [1:0]    row_q_reg;
    logic [1:0]    plane_q_reg;

    // stores: bit 0/1 of a word is the row (plane) of even/odd y (z)
    logic [1:0] row_mem   [0:MAX_X-1];
    logic [1:0] plane_mem [0:MAX_Y-1][0:MAX_X-1];

    // output register
    logic result_valid_reg, result_valid_next;
    logic voxel_out_reg, volume_last_reg;

    logic accept, adv1, adv2, adv3;
    logic [SIZE_W-1:0] sx_c, sy_c, sz_c;
    logic [SIZE_W-1:0] x_ext, y_ext, z_ext;

    logic             v_bit;
    logic [LIN_W-1:0] lin, idx;
    logic             emit;
    logic [TOT_W-1:0] out_inc;
    logic             res_valid, res_voxel, res_last;

    assign cfg_ready = 1'b1;

    assign adv3       = s3_valid_reg && (!result_valid_reg || !result_stall);
    assign adv2       = s2_valid_reg && (!s3_valid_reg || adv3);
    assign adv1       = s1_valid_reg && (!s2_valid_reg || adv2);
    assign item_stall = s1_valid_reg && !adv1;
    assign accept     = item_valid && !item_stall;

    // ---------------- accept stage ----------------
    always_comb
    begin
        sx_c  = clamp_size(size_x_reg, CAP_X);
        sy_c  = clamp_size(size_y_reg, CAP_Y);
        sz_c  = clamp_size(size_z_reg, CAP_Z);
        x_ext = SIZE_W'(pos_x_reg);
        y_ext = SIZE_W'(pos_y_reg);
        z_ext = SIZE_W'(pos_z_reg);

        s1_next.kind     = kind;
        s1_next.h        = voxel_in | x_window_reg[0] | x_window_reg[1];
        s1_next.has_x    = (pos_x_reg != '0);
        s1_next.has_y    = (pos_y_reg != '0);
        s1_next.interior = (x_ext >= 9'd2) && (x_ext + 9'd1 <= sx_c) &&
                           (y_ext >= 9'd2) && (y_ext + 9'd1 <= sy_c) &&
                           (z_ext >= 9'd2) && (z_ext + 9'd1 <= sz_c);
        s1_next.last     = (x_ext + 9'd1 >= sx_c) && (y_ext + 9'd1 >= sy_c) &&
                           (z_ext + 9'd1 >= sz_c);
        s1_next.x        = pos_x_reg;
        s1_next.y        = pos_y_reg;
        s1_next.z        = pos_z_reg;
        s1_next.sx       = sx_c;
        s1_next.sy       = sy_c;
        s1_next.sz       = sz_c;

        // centre column and row of the window, held in range at the edges
        cx_next = (pos_x_reg == '0) ? '0 : XW'(pos_x_reg - 8'd1);
        cy_next = (pos_y_reg == '0) ? '0 : YW'(pos_y_reg - 8'd1);

        x_window_next = x_window_reg;
        pos_x_next    = pos_x_reg;
        pos_y_next    = pos_y_reg;
        pos_z_next    = pos_z_reg;
        if (accept && kind == KIND_VOXEL)
        begin
            x_window_next = {x_window_reg[0], voxel_in};
            if (x_ext + 9'd1 < sx_c)
            begin
                pos_x_next = pos_x_reg + 8'd1;
            end
            else
            begin
                pos_x_next = '0;
                if (y_ext + 9'd1 < sy_c)
                begin
                    pos_y_next = pos_y_reg + 8'd1;
                end
                else
                begin
                    pos_y_next = '0;
                    pos_z_next = (z_ext + 9'd1 < sz_c) ? pos_z_reg + 8'd1 : '0;
                end
            end
        end
    end

    // ---------------- stores ----------------
    // consecutive voxels share a column only at a row wrap with an x extent of two
    // or less, where the read is unused; else a write and a read never meet on one edge
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_q_reg   <= row_mem[cx_next];
            plane_q_reg <= plane_mem[cy_next][cx_next];
        end
        if (adv1 && s1_reg.kind == KIND_VOXEL && s1_reg.has_x)
        begin
            row_mem[s1_cx_reg][s1_reg.y[0]] <= s1_reg.h;
        end
        if (adv1 && s1_reg.kind == KIND_VOXEL && s1_reg.has_x && s1_reg.has_y)
        begin
            plane_mem[s1_cy_reg][s1_cx_reg][s1_reg.z[0]] <= v_bit;
        end
    end

    // ---------------- stage 1 -> 2 ----------------
    always_comb
    begin
        v_bit        = s1_reg.h | row_q_reg[0] | row_q_reg[1];
        s2_next.kind = s1_reg.kind;
        s2_next.dil  = s1_reg.interior & (v_bit | plane_q_reg[0] | plane_q_reg[1]);
        s2_next.last = s1_reg.last;
        s2_next.x    = s1_reg.x;
        s2_next.y    = s1_reg.y;
        s2_next.sx   = s1_reg.sx;
        s2_next.sz   = s1_reg.sz;
        s2_next.zy   = ZY_W'(s1_reg.z) * ZY_W'(s1_reg.sy);
        s2_next.sxy  = SXY_W'(s1_reg.sx) * SXY_W'(s1_reg.sy);
    end

    // ---------------- stage 2 -> 3 ----------------
    always_comb
    begin
        s3_next.kind  = s2_reg.kind;
        s3_next.dil   = s2_reg.dil;
        s3_next.last  = s2_reg.last;
        s3_next.x     = s2_reg.x;
        s3_next.q     = LIN_W'(s2_reg.zy + ZY_W'(s2_reg.y)) * LIN_W'(s2_reg.sx);
        s3_next.total = TOT_W'(s2_reg.sxy) * TOT_W'(s2_reg.sz);
        s3_next.delay = DLY_W'(s2_reg.sxy) + DLY_W'(s2_reg.sx) + DLY_W'(1);
    end

    // ---------------- stage 3 -> output ----------------
    always_comb
    begin
        lin     = s3_reg.q + LIN_W'(s3_reg.x);
        emit    = (lin >= LIN_W'(s3_reg.delay));
        idx     = lin - LIN_W'(s3_reg.delay);
        out_inc = TOT_W'(out_index_reg) + TOT_W'(1);

        out_index_next     = out_index_reg;
        drain_pending_next = drain_pending_reg;
        res_valid          = 1'b0;
        res_voxel          = 1'b0;
        res_last           = 1'b0;

        if (adv3)
        begin
            if (s3_reg.kind == KIND_DRAIN)
            begin
                if (drain_pending_reg)
                begin
                    if (TOT_W'(out_index_reg) >= s3_reg.total)
                    begin
                        drain_pending_next = 1'b0;
                        out_index_next     = '0;
                    end
                    else
                    begin
                        // drained positions all lie on the border
                        res_valid = 1'b1;
                        res_last  = (TOT_W'(out_index_reg) == s3_reg.total - TOT_W'(1));
                        if (out_inc >= s3_reg.total)
                        begin
                            drain_pending_next = 1'b0;
                            out_index_next     = '0;
                        end
                        else
                        begin
                            out_index_next = IDX_W'(out_inc);
                        end
                    end
                end
            end
            else
            begin
                res_valid          = emit;
                res_voxel          = s3_reg.dil;
                res_last           = (TOT_W'(idx) == s3_reg.total - TOT_W'(1));
                out_index_next     = emit ? idx + IDX_W'(1) : '0;
                drain_pending_next = s3_reg.last;
            end
        end

        if (adv3)
        begin
            result_valid_next = res_valid;
        end
        else
        begin
            result_valid_next = result_valid_reg && result_stall;
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg        <= SIZE_RESET;
            size_y_reg        <= SIZE_RESET;
            size_z_reg        <= SIZE_RESET;
            pos_x_reg         <= '0;
            pos_y_reg         <= '0;
            pos_z_reg         <= '0;
            x_window_reg      <= '0;
            out_index_reg     <= '0;
            drain_pending_reg <= 1'b0;
            s1_valid_reg      <= 1'b0;
            s2_valid_reg      <= 1'b0;
            s3_valid_reg      <= 1'b0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SIZE_X: size_x_reg <= cfg_data;
                    CFG_SIZE_Y: size_y_reg <= cfg_data;
                    CFG_SIZE_Z: size_z_reg <= cfg_data;
                    default:    ;
                endcase
            end
            pos_x_reg         <= pos_x_next;
            pos_y_reg         <= pos_y_next;
            pos_z_reg         <= pos_z_next;
            x_window_reg      <= x_window_next;
            out_index_reg     <= out_index_next;
            drain_pending_reg <= drain_pending_next;
            s1_valid_reg      <= accept || (s1_valid_reg && !adv1);
            s2_valid_reg      <= adv1 || (s2_valid_reg && !adv2);
            s3_valid_reg      <= adv2 || (s3_valid_reg && !adv3);
            result_valid_reg  <= result_valid_next;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg    <= s1_next;
            s1_cx_reg <= cx_next;
            s1_cy_reg <= cy_next;
        end
        if (adv1)
        begin
            s2_reg <= s2_next;
        end
        if (adv2)
        begin
            s3_reg <= s3_next;
        end
        if (adv3 && res_valid)
        begin
            voxel_out_reg   <= res_voxel;
            volume_last_reg <= res_last;
        end
    end

    assign result_valid = result_valid_reg;
    assign voxel_out    = voxel_out_reg;
    assign volume_last  = volume_last_reg;

`ifndef SYNTH
    // a held input can only come from a full first stage
    a_stall_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> s1_valid_reg)
        else $error("input stalled with empty first stage");

    // the final voxel of a volume sits on the border
    a_last_is_border: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && volume_last) |-> !voxel_out)
        else $error("last voxel of volume dilated to one");

    // a drain tick with nothing pending produces no transaction
    a_idle_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (adv3 && s3_reg.kind == KIND_DRAIN && !drain_pending_reg) |=> !result_valid)
        else $error("drain tick without pending outputs produced a result");
`endif

endmodule

FILE: tb/binary_volume_dilation_cube_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_volume_dilation_cube_unit_tb - self-checking bench of the dilation unit
// A short table of directed transactions, then random volumes with random
// content, sizes and idling on both sides. Table rows give their own expected
// results; the rest are checked against an in-bench model of the 3x3x3 dilation.
// ----------------------------------------------------------------------------
module binary_volume_dilation_cube_unit_tb
    import bvd_pkg::*;
;

    localparam int DEPTH_X     = 256;
    localparam int DEPTH_Y     = 256;
    localparam int DEPTH_Z     = 256;
    localparam int LATENCY     = 3;
    localparam int VOXEL_ITEMS = 1150;
    localparam int QUIET_LIMIT = 400;

    // register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic voxel;
        logic last;
    } dil_res_t;

    typedef enum logic [1:0] {ROW_VOXEL, ROW_DRAIN, ROW_SIZES} row_kind_t;

    typedef struct {
        row_kind_t         act;
        logic              bit_in;
        logic [SIZE_W-1:0] sx;
        logic [SIZE_W-1:0] sy;
        logic [SIZE_W-1:0] sz;
        bit                typed;
        bit                has_res;
        logic              exp_voxel;
        logic              exp_last;
    } row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_stall;
    logic                 kind = KIND_VOXEL;
    logic                 voxel_in = 1'b0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    logic                 voxel_out;
    logic                 volume_last;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_SIZE_X;
    logic [SIZE_W-1:0]    cfg_data = '0;

    // model state of the unit
    logic [SIZE_W-1:0] reg_sx = SIZE_RESET;
    logic [SIZE_W-1:0] reg_sy = SIZE_RESET;
    logic [SIZE_W-1:0] reg_sz = SIZE_RESET;
    int unsigned       pos_x = 0;
    int unsigned       pos_y = 0;
    int unsigned       pos_z = 0;
    int unsigned       next_out = 0;
    bit [1:0]          x_hist = '0;
    bit                drain_due = 1'b0;
    bit                row_or [2*DEPTH_X];
    bit                plane_or [2*DEPTH_X*DEPTH_Y];

    dil_res_t    dilated_q [$];
    int          errors = 0;
    int unsigned stim_count = 0;
    int unsigned quiet_cycles = 0;
    bit          sender_rush = 1'b0;
    bit          receiver_rush = 1'b0;
    int unsigned stall_left = 0;

    row_t opening_rows [21] = '{
        '{ROW_VOXEL, 1'b1, 9'd0, 9'd0, 9'd0, 1'b1, 1'b0, 1'b0, 1'b0},
        '{ROW_VOXEL, 1'b0, 9'd0, 9'd0, 9'd0, 1'b1, 1'b0, 1'b0, 1'b0},
        '{ROW_DRAIN, 1'b1, 9'd0, 9'd0, 9'd0, 1'b1, 1'b0, 1'b0, 1'b0},
        '{ROW_VOXEL, 1'b1, 9'd0, 9'd0, 9'd0, 1'b1, 1'b0, 1'b0, 1'b0},
        // zero sizes act as one, mid-volume: the next voxel closes the volume
        '{ROW_SIZES, 1'b0, 9'd0, 9'd0, 9'd0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_VOXEL, 1'b1, 9'd0, 9'd0, 9'd0, 1'b1, 1'b1, 1'b0, 1'b1},
        '{ROW_DRAIN, 1'b0, 9'd0, 9'd0, 9'd0, 1'b1, 1'b0, 1'b0, 1'b0},
        // 2x2x2: all border, only the last voxel is past the delay
        '{ROW_SIZES, 1'b0, 9'd2, 9'd2, 9'd2, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_VOXEL, 1'b1, 9'd0, 9'd0, 9'd0, 1'b1, 1'b0, 1'b0, 1'b0},
        '{ROW_VOXEL, 1'b0, 9'd0, 9'd0, 9'd0, 1'b1, 1'b0, 1'b0, 1'b0},
        '{ROW_VOXEL, 1'b1, 9'd0, 9'd0, 9'd0, 1'b1, 1'b0, 1'b0, 1'b0},
        '{ROW_VOXEL, 1'b1, 9'd0, 9'd0, 9'd0, 1'b1, 1'b0, 1'b0, 1'b0},
        '{ROW_VOXEL, 1'b0, 9'd0, 9'd0, 9'd0, 1'b1, 1'b0, 1'b0, 1'b0},
        '{ROW_VOXEL, 1'b1, 9'd0, 9'd0, 9'd0, 1'b1, 1'b0, 1'b0, 1'b0},
        '{ROW_VOXEL, 1'b1, 9'd0, 9'd0, 9'd0, 1'b1, 1'b0, 1'b0, 1'b0},
        '{ROW_VOXEL, 1'b1, 9'd0, 9'd0, 9'd0, 1'b1, 1'b1, 1'b0, 1'b0},
        '{ROW_DRAIN, 1'b1, 9'd0, 9'd0, 9'd0, 1'b1, 1'b1, 1'b0, 1'b0},
        '{ROW_DRAIN, 1'b0, 9'd0, 9'd0, 9'd0, 1'b1, 1'b1, 1'b0, 1'b0},
        '{ROW_DRAIN, 1'b0, 9'd0, 9'd0, 9'd0, 1'b1, 1'b1, 1'b0, 1'b0},
        // a voxel drops the pending outputs and opens the next volume
        '{ROW_VOXEL, 1'b1, 9'd0, 9'd0, 9'd0, 1'b1, 1'b0, 1'b0, 1'b0},
        '{ROW_DRAIN, 1'b1, 9'd0, 9'd0, 9'd0, 1'b1, 1'b0, 1'b0, 1'b0}
    };

    binary_volume_dilation_cube_unit #(
        .MAX_X (DEPTH_X),
        .MAX_Y (DEPTH_Y),
        .MAX_Z (DEPTH_Z)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .kind         (kind),
        .voxel_in     (voxel_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .voxel_out    (voxel_out),
        .volume_last  (volume_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int unsigned eff_size(input logic [SIZE_W-1:0] r);
        int unsigned v;
        v = 32'(r);
        if (v < 1) v = 1;
        if (v > SIZE_CAP) v = SIZE_CAP;
        return v;
    endfunction

    function automatic int unsigned drains_owed();
        int unsigned total;
        total = eff_size(reg_sx) * eff_size(reg_sy) * eff_size(reg_sz);
        if (!drain_due)
            return 0;
        return (next_out < total) ? total - next_out : 1;
    endfunction

    // one accepted transaction: a drain, or a voxel through the separable x, y and z ORs
    task automatic dilate_step(input logic k, input logic b, output bit produced,
                               output dil_res_t r);
        int unsigned sx, sy, sz, total, delay, x, y, z, lin, idx;
        int unsigned cx, cy, cur, prv, pc, pp;
        bit          h, v, res, interior, at_end;
        sx = eff_size(reg_sx);
        sy = eff_size(reg_sy);
        sz = eff_size(reg_sz);
        total = sx * sy * sz;
        delay = sx * sy + sx + 1;
        x = pos_x;
        y = pos_y;
        z = pos_z;
        v = 1'b0;
        res = 1'b0;
        produced = 1'b0;
        r = '0;
        if (k == KIND_DRAIN)
        begin
            if (drain_due)
            begin
                if (next_out >= total)
                begin
                    drain_due = 1'b0;
                    next_out = 0;
                end
                else
                begin
                    produced = 1'b1;
                    r.last = (next_out == total - 1);
                    next_out++;
                    if (next_out >= total)
                    begin
                        drain_due = 1'b0;
                        next_out = 0;
                    end
                end
            end
        end
        else
        begin
            drain_due = 1'b0;
            h = b | x_hist[0] | x_hist[1];
            x_hist = {x_hist[0], b};
            if (x >= 1)
            begin
                cx = (x - 1) % DEPTH_X;
                cur = (y & 1) * DEPTH_X + cx;
                prv = ((y + 1) & 1) * DEPTH_X + cx;
                v = h | row_or[prv] | row_or[cur];
                row_or[cur] = h;
                if (y >= 1)
                begin
                    cy = (y - 1) % DEPTH_Y;
                    pc = (z & 1) * DEPTH_X * DEPTH_Y + cy * DEPTH_X + cx;
                    pp = ((z + 1) & 1) * DEPTH_X * DEPTH_Y + cy * DEPTH_X + cx;
                    res = v | plane_or[pp] | plane_or[pc];
                    plane_or[pc] = v;
                end
            end
            interior = x >= 2 && x + 1 <= sx && y >= 2 && y + 1 <= sy &&
                       z >= 2 && z + 1 <= sz;
            lin = (z * sy + y) * sx + x;
            at_end = x + 1 >= sx && y + 1 >= sy && z + 1 >= sz;
            if (x + 1 < sx)
                pos_x = x + 1;
            else
            begin
                pos_x = 0;
                if (y + 1 < sy)
                    pos_y = y + 1;
                else
                begin
                    pos_y = 0;
                    pos_z = (z + 1 < sz) ? z + 1 : 0;
                end
            end
            if (lin >= delay)
            begin
                idx = lin - delay;
                produced = 1'b1;
                r.voxel = interior ? res : 1'b0;
                r.last = (idx == total - 1);
                next_out = (idx + 1) & 24'hFFFFFF;
            end
            else
                next_out = 0;
            if (at_end)
                drain_due = 1'b1;
        end
    endtask

    task automatic send_item(input logic k, input logic b, input bit typed = 1'b0,
                             input bit typed_has = 1'b0, input dil_res_t typed_res = '0);
        int unsigned gap;
        bit          produced;
        dil_res_t    r;
        gap = sender_rush ? 0 : $urandom_range(0, 12);
        if ($urandom_range(0, 39) == 0)
            sender_rush = !sender_rush;
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        kind <= k;
        voxel_in <= b;
        do @(posedge clk); while (item_stall !== 1'b0);
        if (k == KIND_VOXEL || drain_due)
            stim_count++;
        dilate_step(k, b, produced, r);
        if (typed)
        begin
            if (typed_has)
                dilated_q.push_back(typed_res);
        end
        else if (produced)
            dilated_q.push_back(r);
    endtask

    // sender holds off until every result is in and the pipeline has emptied
    task automatic wait_quiet();
        item_valid <= 1'b0;
        while (dilated_q.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_sizes(input logic [SIZE_W-1:0] a, input logic [SIZE_W-1:0] b,
                               input logic [SIZE_W-1:0] c);
        logic [CFG_IDX_W-1:0] codes [4];
        logic [SIZE_W-1:0]    vals [4];
        int                   n;
        codes = '{CFG_SIZE_X, CFG_SIZE_Y, CFG_SIZE_Z, CFG_UNUSED};
        vals = '{a, b, c, SIZE_W'($urandom_range(0, 511))};
        n = ($urandom_range(0, 3) == 0) ? 4 : 3;
        for (int i = 0; i < n; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= codes[i];
            cfg_data <= vals[i];
            do @(posedge clk); while (cfg_ready !== 1'b1);
            case (codes[i])
                CFG_SIZE_X: reg_sx = vals[i];
                CFG_SIZE_Y: reg_sy = vals[i];
                CFG_SIZE_Z: reg_sz = vals[i];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic flush_drains();
        while (drain_due)
            send_item(KIND_DRAIN, 1'($urandom_range(0, 1)));
    endtask

    // sizes of one close the current volume on the next voxel
    task automatic cut_volume();
        write_sizes(SIZE_W'($urandom_range(0, 1)), SIZE_W'($urandom_range(0, 1)),
                    SIZE_W'($urandom_range(0, 1)));
        send_item(KIND_VOXEL, 1'($urandom_range(0, 1)));
        flush_drains();
    endtask

    task automatic run_extreme(input int which);
        int unsigned n;
        case (which)
            0:
            begin
                write_sizes(9'd511, 9'd3, 9'd3);
                n = 40;
            end
            1:
            begin
                write_sizes(9'd2, 9'd256, 9'd2);
                n = 40;
            end
            2:
            begin
                write_sizes(9'd4, 9'd4, 9'd256);
                n = 70;
            end
            default:
            begin
                write_sizes(9'd256, SIZE_W'($urandom_range(256, 511)),
                            SIZE_W'($urandom_range(256, 511)));
                n = 30;
            end
        endcase
        repeat (n)
            send_item(KIND_VOXEL, 1'($urandom_range(0, 1)));
    endtask

    task automatic run_volume();
        int unsigned sx, sy, sz, density, z_at, count, owed, n;
        bit          z_move;
        sx = $urandom_range(1, 8);
        sy = $urandom_range(1, 6);
        sz = $urandom_range(1, 5);
        density = $urandom_range(0, 100);
        z_move = ($urandom_range(0, 5) == 0);
        z_at = $urandom_range(1, sx * sy * sz);
        count = 0;
        write_sizes(SIZE_W'(sx), SIZE_W'(sy), SIZE_W'(sz));
        do
        begin
            if ($urandom_range(0, 29) == 0)
                send_item(KIND_DRAIN, 1'($urandom_range(0, 1)));
            send_item(KIND_VOXEL, $urandom_range(0, 99) < density);
            count++;
            // z extent changed part-way; x and y keep their values
            if (z_move && count == z_at)
            begin
                wait_quiet();
                write_sizes(SIZE_W'(sx), SIZE_W'(sy), SIZE_W'($urandom_range(1, 6)));
            end
        end
        while (pos_x != 0 || pos_y != 0 || pos_z != 0);
        owed = drains_owed();
        if ($urandom_range(0, 7) == 0 && owed != 0)
            n = $urandom_range(0, owed - 1);
        else
            n = owed + $urandom_range(0, 1);
        repeat (n)
            send_item(KIND_DRAIN, 1'($urandom_range(0, 1)));
    endtask

    // result side: check each transaction, then draw the next stall
    always @(posedge clk)
    begin : result_side
        int unsigned hold;
        dil_res_t    want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (dilated_q.size() == 0)
            begin
                errors++;
                $display("%0t: result with none expected, voxel_out %0b volume_last %0b",
                         $time, voxel_out, volume_last);
            end
            else
            begin
                want = dilated_q.pop_front();
                if (want.voxel !== voxel_out)
                begin
                    errors++;
                    $display("%0t: voxel_out expected %0b, got %0b",
                             $time, want.voxel, voxel_out);
                end
                if (want.last !== volume_last)
                begin
                    errors++;
                    $display("%0t: volume_last expected %0b, got %0b",
                             $time, want.last, volume_last);
                end
            end
            hold = receiver_rush ? 0 : $urandom_range(0, 12);
            if ($urandom_range(0, 39) == 0)
                receiver_rush = !receiver_rush;
            stall_left <= hold;
            result_stall <= (hold != 0);
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            result_stall <= (stall_left > 1);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
        $display("binary_volume_dilation_cube_unit_tb: errors");
        $finish;
    end

    initial
    begin : stimulus
        int       phase;
        int       extreme;
        dil_res_t typed_res;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (opening_rows[i])
        begin
            typed_res = {opening_rows[i].exp_voxel, opening_rows[i].exp_last};
            case (opening_rows[i].act)
                ROW_SIZES:
                begin
                    wait_quiet();
                    write_sizes(opening_rows[i].sx, opening_rows[i].sy, opening_rows[i].sz);
                end
                ROW_VOXEL:
                    send_item(KIND_VOXEL, opening_rows[i].bit_in, opening_rows[i].typed,
                              opening_rows[i].has_res, typed_res);
                default:
                    send_item(KIND_DRAIN, opening_rows[i].bit_in, opening_rows[i].typed,
                              opening_rows[i].has_res, typed_res);
            endcase
        end

        stim_count = 0;
        phase = 0;
        while (stim_count < VOXEL_ITEMS)
        begin
            if (phase < 4)
                extreme = phase;
            else
                extreme = ($urandom_range(0, 14) == 0) ? $urandom_range(0, 3) : -1;
            phase++;
            wait_quiet();
            if (pos_x != 0 || pos_y != 0 || pos_z != 0)
            begin
                cut_volume();
                wait_quiet();
            end
            if (extreme >= 0)
                run_extreme(extreme);
            else
                run_volume();
            if ($urandom_range(0, 5) == 0)
                wait_quiet();
        end

        item_valid <= 1'b0;
        while (dilated_q.size() != 0) @(posedge clk);
        repeat (4 * LATENCY) @(posedge clk);
        if (errors == 0)
            $display("binary_volume_dilation_cube_unit_tb: clean");
        else
            $display("binary_volume_dilation_cube_unit_tb: errors");
        $finish;
    end

endmodule

FILE: binary_volume_dilation_cube_unit.f
design/bvd_pkg.sv
design/binary_volume_dilation_cube_unit.sv
tb/binary_volume_dilation_cube_unit_tb.sv
